// ===== hdl/clfr_pkg.sv =====
// shared types and byte codes of the chain LED frame receiver
package clfr_pkg;

	localparam int PLANES = 8;
	localparam int LANES  = 8;

	localparam logic [7:0] SYNC_BYTE = 8'h7E;
	localparam logic [7:0] MY_ADDR   = 8'h80;
	localparam logic [7:0] PAD_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_BYTE  = 8'h7F;
	localparam logic [7:0] DONE_BYTE = 8'h80;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [4:0] {
		PH_SYNC = 5'b00001,
		PH_ADDR = 5'b00010,
		PH_DATA = 5'b00100,
		PH_HOLD = 5'b01000,
		PH_PASS = 5'b10000
	} clfr_phase_t;

	typedef struct packed {
		logic       en;
		logic [3:0] page;
		logic [7:0] lanes;
		logic [7:0] value;
	} clfr_wr_t;

	typedef struct packed {
		logic       en;
		logic [5:0] index;
	} clfr_rd_t;

endpackage

// ===== hdl/chain_led_frame_receiver.sv =====
// chain LED frame receiver: sync/address/data parsing, pass-through and bit-plane buffer
// a result is registered twice on its way out: first in the input register, then in the result register
// throughput: one item per cycle while the output does not stall; one shallow update of the parser state per item
// a waiting result does not block one more input transfer into the input register
// reset: parser waits for sync, page limit 4, buffer reads 0xFF via per-lane flags
module chain_led_frame_receiver #(
	parameter int MAX_PAGES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic [5:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       frame_done,
	output logic [7:0] read_data
);

	logic [3:0] pages_used_q;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic [5:0] idx_s1;

	logic       valid_s2;
	logic       txv_s2;
	logic [7:0] txb_s2;
	logic       done_s2;
	logic       rd_s2;

	clfr_pkg::clfr_phase_t phase_q, phase_d;
	logic [3:0] page_q, page_d;
	logic [2:0] chan_q, chan_d;
	logic [7:0] lane_q, lane_d;

	logic       s2_load, s1_adv, s1_load;
	logic       txv_d, done_d, rd_ok;
	logic [7:0] txb_d, lane_rot, buf_byte;
	logic [3:0] limit, page_nx;

	clfr_pkg::clfr_wr_t wr;
	clfr_pkg::clfr_rd_t rd;

	assign s2_load  = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && s2_load;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_stall = !s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_used_q <= 4'd4;
		end else if (cfg_we) begin
			pages_used_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (pages_used_q == 4'd0) begin
			limit = 4'd1;
		end else if (pages_used_q > 4'(MAX_PAGES)) begin
			limit = 4'(MAX_PAGES);
		end else begin
			limit = pages_used_q;
		end
	end

	assign rd_ok    = {1'b0, idx_s1[5:3]} < 4'(MAX_PAGES);
	assign lane_rot = {lane_q[6:0], lane_q[7]};
	assign page_nx  = page_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		page_d   = page_q;
		chan_d   = chan_q;
		lane_d   = lane_q;
		txv_d    = 1'b0;
		txb_d    = '0;
		done_d   = 1'b0;
		wr.en    = 1'b0;
		wr.page  = page_q;
		wr.lanes = lane_rot;
		wr.value = byte_s1;
		if (op_s1 == clfr_pkg::OP_RX) begin
			unique case (phase_q)
				clfr_pkg::PH_SYNC: begin
					if (byte_s1 == clfr_pkg::SYNC_BYTE) begin
						phase_d = clfr_pkg::PH_ADDR;
						txv_d   = 1'b1;
						txb_d   = clfr_pkg::SYNC_BYTE;
					end
				end
				clfr_pkg::PH_ADDR: begin
					if (byte_s1 == clfr_pkg::MY_ADDR) begin
						phase_d = clfr_pkg::PH_DATA;
						page_d  = '0;
						chan_d  = '0;
						lane_d  = 8'd1;
					end else if (byte_s1 > clfr_pkg::MY_ADDR) begin
						phase_d = clfr_pkg::PH_PASS;
						txv_d   = 1'b1;
						txb_d   = byte_s1 - 8'd1;
					end
				end
				clfr_pkg::PH_DATA: begin
					if (byte_s1 == clfr_pkg::ESC_BYTE) begin
						phase_d = clfr_pkg::PH_HOLD;
					end else if (byte_s1 != clfr_pkg::PAD_BYTE) begin
						wr.en  = page_q < 4'(MAX_PAGES);
						lane_d = lane_rot;
						chan_d = chan_q + 3'd1;
						// seventh channel closes the page
						if (chan_q == 3'd6) begin
							page_d = page_nx;
							chan_d = '0;
							lane_d = (page_nx < 4'd8) ? (8'd1 << page_nx[2:0]) : 8'd0;
							if (page_nx >= limit) begin
								done_d  = 1'b1;
								phase_d = clfr_pkg::PH_PASS;
								txv_d   = 1'b1;
								txb_d   = clfr_pkg::DONE_BYTE;
							end
						end
					end
				end
				clfr_pkg::PH_PASS: begin
					if (byte_s1 == clfr_pkg::SYNC_BYTE) begin
						phase_d = clfr_pkg::PH_ADDR;
					end
					txv_d = 1'b1;
					txb_d = byte_s1;
				end
				default: begin
				end
			endcase
		end
		wr.en    = wr.en && s1_adv;
		rd.en    = s1_adv && (op_s1 == clfr_pkg::OP_READ) && rd_ok;
		rd.index = idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= clfr_pkg::PH_SYNC;
			page_q   <= '0;
			chan_q   <= '0;
			lane_q   <= 8'd1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				phase_q <= phase_d;
				page_q  <= page_d;
				chan_q  <= chan_d;
				lane_q  <= lane_d;
			end
			if (s1_load) begin
				valid_s1 <= in_valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_load) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
			idx_s1  <= read_index;
		end
		if (s1_adv) begin
			txv_s2  <= txv_d;
			txb_s2  <= txb_d;
			done_s2 <= done_d;
			rd_s2   <= rd.en;
		end
	end

	clfr_plane_buf #(
		.MAX_PAGES(MAX_PAGES)
	) u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rd_byte(buf_byte)
	);

	assign out_valid  = valid_s2;
	assign tx_valid   = txv_s2;
	assign tx_byte    = txb_s2;
	assign frame_done = done_s2;
	assign read_data  = rd_s2 ? buf_byte : 8'd0;

	a_done_sends_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> tx_valid && tx_byte == clfr_pkg::DONE_BYTE)
		else $error("frame end without done byte");

	a_read_sends_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> !tx_valid)
		else $error("buffer read also sent a byte");

	a_empty_input_reg_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input register");

	a_lane_single: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == clfr_pkg::PH_DATA |-> $onehot0(lane_q))
		else $error("lane mask has more than one lane");

	a_page_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && wr.en |=> page_q <= 4'(MAX_PAGES))
		else $error("page counter ran past the limit");

endmodule

// ===== hdl/clfr_plane_buf.sv =====
// bit-plane buffer: one row per page, lane-masked writes, registered byte read
module clfr_plane_buf #(
	parameter int MAX_PAGES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clfr_pkg::clfr_wr_t wr,
	input  clfr_pkg::clfr_rd_t rd,
	output logic [7:0]        rd_byte
);

	localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int ROW_W  = clfr_pkg::PLANES * clfr_pkg::LANES;

	logic [ROW_W-1:0]          mem [MAX_PAGES];
	logic [clfr_pkg::LANES-1:0] lane_ok_q [MAX_PAGES];
	logic [ROW_W-1:0]          row_q;
	logic [clfr_pkg::LANES-1:0] row_ok_q;
	logic [2:0]                plane_q;

	// plane p takes bit 7-p of the value in every enabled lane
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int p = 0; p < clfr_pkg::PLANES; p++) begin
				for (int l = 0; l < clfr_pkg::LANES; l++) begin
					if (wr.lanes[l]) begin
						mem[wr.page[PAGE_W-1:0]][p*clfr_pkg::LANES+l] <= wr.value[7-p];
					end
				end
			end
		end
		if (rd.en) begin
			row_q   <= mem[rd.index[3 +: PAGE_W]];
			plane_q <= rd.index[2:0];
		end
	end

	// lanes never written since reset read as ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				lane_ok_q[i] <= '0;
			end
			row_ok_q <= '0;
		end else begin
			if (wr.en) begin
				lane_ok_q[wr.page[PAGE_W-1:0]] <= lane_ok_q[wr.page[PAGE_W-1:0]] | wr.lanes;
			end
			if (rd.en) begin
				row_ok_q <= lane_ok_q[rd.index[3 +: PAGE_W]];
			end
		end
	end

	assign rd_byte = row_q[plane_q*clfr_pkg::LANES +: clfr_pkg::LANES] | ~row_ok_q;

endmodule

// ===== test/tb_chain_led_frame_receiver.sv =====
// testbench for the chain LED frame receiver: predicted replies checked per transfer
`timescale 1ns / 1ps

module tb_chain_led_frame_receiver;

	localparam int BUF_PAGES  = 8;
	localparam int BUF_BYTES  = BUF_PAGES * clfr_pkg::PLANES;
	localparam int CYCLE_CAP  = 600000;
	localparam int RAND_ITEMS = 1340;

	typedef struct {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       frame_done;
		logic [7:0] read_data;
	} led_reply_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic       op;
	logic [7:0] rx_byte;
	logic [5:0] read_index;
	logic       out_valid;
	logic       out_stall;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       frame_done;
	logic [7:0] read_data;

	// predicted receiver state
	clfr_pkg::clfr_phase_t rx_phase_p;
	logic [3:0]  pages_cfg;
	logic [3:0]  page_cnt;
	logic [2:0]  chan_cnt;
	logic [7:0]  lanes;
	logic [7:0]  planes [BUF_BYTES];

	led_reply_t expected_replies[$];
	int cycle_count;
	int items_sent;
	int replies_checked;
	int mismatch_count;
	int frames_stored;
	int config_writes;
	bit quiet;
	int stall_left;

	chain_led_frame_receiver #(.MAX_PAGES(BUF_PAGES)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.frame_done (frame_done),
		.read_data  (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				expected_replies.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int page_limit();
		if (pages_cfg == 4'd0)
			return 1;
		if (pages_cfg > BUF_PAGES)
			return BUF_PAGES;
		return pages_cfg;
	endfunction

	// writes one channel byte into the current lane of the page's bit planes
	function automatic void store_channel(input logic [7:0] value);
		int base;
		lanes = {lanes[6:0], lanes[7]};
		chan_cnt = chan_cnt + 3'd1;
		if (page_cnt < BUF_PAGES) begin
			base = page_cnt * clfr_pkg::PLANES;
			for (int i = 0; i < clfr_pkg::PLANES; i++) begin
				if (value[7 - i])
					planes[base + i] = planes[base + i] | lanes;
				else
					planes[base + i] = planes[base + i] & ~lanes;
			end
		end
	endfunction

	function automatic led_reply_t advance_receiver(input logic o, input logic [7:0] b,
		input logic [5:0] ri);
		led_reply_t r;
		r = '{1'b0, 8'h00, 1'b0, 8'h00};
		if (o == clfr_pkg::OP_READ) begin
			if (ri < BUF_BYTES)
				r.read_data = planes[ri];
			return r;
		end
		case (rx_phase_p)
			clfr_pkg::PH_SYNC: begin
				if (b == clfr_pkg::SYNC_BYTE) begin
					rx_phase_p = clfr_pkg::PH_ADDR;
					r.tx_valid = 1'b1;
					r.tx_byte = clfr_pkg::SYNC_BYTE;
				end
			end
			clfr_pkg::PH_ADDR: begin
				if (b == clfr_pkg::MY_ADDR) begin
					rx_phase_p = clfr_pkg::PH_DATA;
					page_cnt = 4'd0;
					chan_cnt = 3'd0;
					lanes = 8'h01;
				end else if (b > clfr_pkg::MY_ADDR) begin
					rx_phase_p = clfr_pkg::PH_PASS;
					r.tx_valid = 1'b1;
					r.tx_byte = b - 8'd1;
				end
			end
			clfr_pkg::PH_DATA: begin
				if (b == clfr_pkg::ESC_BYTE) begin
					rx_phase_p = clfr_pkg::PH_HOLD;
				end else if (b != clfr_pkg::PAD_BYTE) begin
					store_channel(b);
					if (chan_cnt == 3'd7) begin
						page_cnt = page_cnt + 4'd1;
						chan_cnt = 3'd0;
						lanes = (page_cnt < 8) ? 8'h01 << page_cnt : 8'h00;
						if (page_cnt >= page_limit()) begin
							rx_phase_p = clfr_pkg::PH_PASS;
							r.frame_done = 1'b1;
							r.tx_valid = 1'b1;
							r.tx_byte = clfr_pkg::DONE_BYTE;
							frames_stored++;
						end
					end
				end
			end
			clfr_pkg::PH_PASS: begin
				if (b == clfr_pkg::SYNC_BYTE)
					rx_phase_p = clfr_pkg::PH_ADDR;
				r.tx_valid = 1'b1;
				r.tx_byte = b;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// receive side: random stalls, mostly short
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (quiet || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(5, 25);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		led_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected reply tx_valid=%b tx_byte=%h done=%b rd=%h",
						$realtime, tx_valid, tx_byte, frame_done, read_data);
			end else begin
				want = expected_replies.pop_front();
				replies_checked++;
				if (tx_valid !== want.tx_valid || tx_byte !== want.tx_byte ||
					frame_done !== want.frame_done || read_data !== want.read_data) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: reply %0d want %b/%h %b %h, got %b/%h %b %h",
							$realtime, replies_checked, want.tx_valid, want.tx_byte,
							want.frame_done, want.read_data, tx_valid, tx_byte,
							frame_done, read_data);
				end
			end
		end
	end

	task automatic send_item(input logic o, input logic [7:0] b, input logic [5:0] ri);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		rx_byte <= b;
		read_index <= ri;
		do @(posedge clk); while (in_stall);
		expected_replies.push_back(advance_receiver(o, b, ri));
		items_sent++;
	endtask

	task automatic send_rx(input logic [7:0] b);
		send_item(clfr_pkg::OP_RX, b, 6'($urandom));
	endtask

	task automatic send_read(input logic [5:0] ri);
		send_item(clfr_pkg::OP_READ, 8'($urandom), ri);
	endtask

	// lowers valid right after the last transfer, then lets the pipeline drain
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_page_count(input logic [3:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pages_cfg = value;
		config_writes++;
	endtask

	task automatic reach_data_phase();
		while (rx_phase_p != clfr_pkg::PH_DATA) begin
			if (rx_phase_p == clfr_pkg::PH_ADDR)
				send_rx(clfr_pkg::MY_ADDR);
			else
				send_rx(clfr_pkg::SYNC_BYTE);
		end
	endtask

	// channel bytes never carry the escape code here, the hold state is tested last
	task automatic send_channel();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == clfr_pkg::ESC_BYTE)
			b = 8'hFF;
		send_rx(b);
	endtask

	task automatic feed_frame(input int read_pct, input int pad_pct);
		int r;
		reach_data_phase();
		while (rx_phase_p == clfr_pkg::PH_DATA) begin
			r = $urandom_range(0, 99);
			if (r < read_pct)
				send_read(6'($urandom));
			else if (r < read_pct + pad_pct)
				send_rx(clfr_pkg::PAD_BYTE);
			else
				send_channel();
		end
	endtask

	task automatic test_reset_contents();
		send_read(6'd0);
		send_read(6'd63);
		send_read(6'd21);
	endtask

	task automatic test_frame_basics();
		write_page_count(4'd0);
		send_rx(8'h00);
		send_rx(clfr_pkg::SYNC_BYTE);
		send_rx(8'h05);
		send_rx(clfr_pkg::MY_ADDR);
		send_rx(8'hFF);
		send_rx(8'h00);
		send_rx(clfr_pkg::PAD_BYTE);
		send_rx(8'hA5);
		send_rx(8'h5A);
		send_rx(8'h80);
		send_rx(8'h01);
		send_rx(clfr_pkg::SYNC_BYTE);
		// frame is stored, now passing through
		send_rx(clfr_pkg::ESC_BYTE);
		send_rx(clfr_pkg::SYNC_BYTE);
		send_rx(8'hFF);
		send_rx(8'h00);
		send_rx(clfr_pkg::SYNC_BYTE);
		send_rx(8'h81);
		send_read(6'd0);
		send_read(6'd7);
		send_read(6'd63);
	endtask

	task automatic test_page_limit_extremes();
		logic [3:0] settings [5];
		settings = '{4'd8, 4'd15, 4'd1, 4'd0, 4'($urandom_range(2, 7))};
		foreach (settings[k]) begin
			write_page_count(settings[k]);
			feed_frame(8, 5);
			repeat (4) send_read(6'($urandom));
		end
		for (int i = 0; i < BUF_BYTES; i += 9)
			send_read(6'(i));
	endtask

	task automatic test_limit_lowered_mid_frame();
		write_page_count(4'd8);
		reach_data_phase();
		repeat (35) send_channel();
		write_page_count(4'd2);
		feed_frame(0, 0);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int r;
		stop_at = items_sent + RAND_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				quiet = ~quiet;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				feed_frame($urandom_range(0, 15), $urandom_range(0, 10));
			end else if (r < 70) begin
				// frame addressed further down the chain
				while (rx_phase_p != clfr_pkg::PH_ADDR) begin
					if (rx_phase_p == clfr_pkg::PH_DATA)
						send_channel();
					else
						send_rx(clfr_pkg::SYNC_BYTE);
				end
				if ($urandom_range(0, 3) == 0)
					send_rx(8'($urandom_range(0, 127)));
				send_rx(8'($urandom_range(129, 255)));
				repeat ($urandom_range(1, 12)) send_rx(8'($urandom));
			end else if (r < 85) begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1))
						send_read(6'($urandom));
					else if (rx_phase_p == clfr_pkg::PH_DATA)
						send_channel();
					else
						send_rx(8'($urandom));
				end
			end else if (r < 95) begin
				repeat ($urandom_range(1, 10)) send_read(6'($urandom));
			end else begin
				write_page_count(4'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	task automatic test_escape_hold();
		reach_data_phase();
		repeat (3) send_channel();
		send_rx(clfr_pkg::ESC_BYTE);
		send_rx(clfr_pkg::SYNC_BYTE);
		send_rx(clfr_pkg::MY_ADDR);
		repeat (10) send_rx(8'($urandom));
		repeat (6) send_read(6'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		in_valid = 1'b0;
		op = clfr_pkg::OP_RX;
		rx_byte = 8'h00;
		read_index = 6'd0;
		out_stall = 1'b0;
		cycle_count = 0;
		items_sent = 0;
		replies_checked = 0;
		mismatch_count = 0;
		frames_stored = 0;
		config_writes = 0;
		quiet = 1'b0;
		stall_left = 0;
		rx_phase_p = clfr_pkg::PH_SYNC;
		pages_cfg = 4'd4;
		page_cnt = 4'd0;
		chan_cnt = 3'd0;
		lanes = 8'h01;
		foreach (planes[i])
			planes[i] = 8'hFF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_frame_basics();
		test_page_limit_extremes();
		test_limit_lowered_mid_frame();
		test_random_traffic();
		test_escape_hold();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d transfers in, %0d replies checked, %0d frames stored, %0d config writes",
			items_sent, replies_checked, frames_stored, config_writes);
		$display("%0d mismatches, %0d replies left over", mismatch_count,
			expected_replies.size());
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
